### rtl/whaq_pkg.sv
// ----------------------------------------------------------------------------
// whaq_pkg
// Shared types and constants for the window height average query block.
// ----------------------------------------------------------------------------
package whaq_pkg;

  localparam int unsigned MaxPoints = 4096;
  localparam int unsigned CoordBits = 24;
  localparam int unsigned IdxBits   = $clog2(MaxPoints);
  localparam int unsigned CntBits   = IdxBits + 1;
  localparam int unsigned SumBits   = CoordBits + IdxBits + 1;
  localparam int unsigned PtBits    = 3 * CoordBits + 1;

  localparam logic signed [CoordBits-1:0] CoordMax = {1'b0, {(CoordBits-1){1'b1}}};
  localparam logic signed [CoordBits-1:0] CoordMin = {1'b1, {(CoordBits-1){1'b0}}};

  typedef enum logic [1:0] {
    CmdLoad  = 2'd0,
    CmdClear = 2'd1,
    CmdQuery = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]                  command;
    logic signed [CoordBits-1:0] coord_x;
    logic signed [CoordBits-1:0] coord_y;
    logic signed [CoordBits-1:0] coord_z;
    logic                        z_present;
    logic [CoordBits-2:0]        radius;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] out_x;
    logic signed [CoordBits-1:0] out_y;
    logic signed [CoordBits-1:0] height;
    logic                        height_ok;
  } out_item_t;

  // query job passed from front to back
  typedef struct packed {
    logic signed [CoordBits-1:0] qx;
    logic signed [CoordBits-1:0] qy;
    logic [CoordBits-2:0]        radius;
    logic                        in_bounds;
    logic [CntBits-1:0]          count;
  } job_t;

  typedef enum logic [2:0] {
    BkIdle, BkRead, BkScan, BkDiv, BkOut
  } bk_state_e;

endpackage

### rtl/whaq_ram.sv
// ----------------------------------------------------------------------------
// whaq_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module whaq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/whaq_front.sv
// ----------------------------------------------------------------------------
// whaq_front
// Accepts items, writes loads into the point store, keeps the bounds and the
// count, and queues query jobs for the back end.
// ----------------------------------------------------------------------------
module whaq_front import whaq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_item_i,
  input  logic               busy_i,
  output logic               job_valid_o,
  output job_t               job_o,
  output logic               we_o,
  output logic [IdxBits-1:0] waddr_o,
  output logic [PtBits-1:0]  wdata_o
);
  logic [CntBits-1:0] count_q, count_d;
  logic signed [CoordBits-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
  logic signed [CoordBits-1:0] min_x_d, max_x_d, min_y_d, max_y_d;
  logic acc, full;

  // store must not change while a scan runs
  assign in_ready_o = !busy_i;
  assign acc        = in_valid_i && in_ready_o;
  assign full       = count_q == CntBits'(MaxPoints);

  assign we_o    = acc && (in_item_i.command == CmdLoad) && !full;
  assign waddr_o = count_q[IdxBits-1:0];
  assign wdata_o = {in_item_i.coord_x, in_item_i.coord_y, in_item_i.coord_z,
                    in_item_i.z_present};

  assign job_valid_o      = acc && (in_item_i.command == CmdQuery);
  assign job_o.qx         = in_item_i.coord_x;
  assign job_o.qy         = in_item_i.coord_y;
  assign job_o.radius     = in_item_i.radius;
  assign job_o.count      = count_q;
  assign job_o.in_bounds  = in_item_i.coord_x >= min_x_q && in_item_i.coord_x <= max_x_q
                         && in_item_i.coord_y >= min_y_q && in_item_i.coord_y <= max_y_q;

  always_comb begin
    count_d = count_q;
    min_x_d = min_x_q;
    max_x_d = max_x_q;
    min_y_d = min_y_q;
    max_y_d = max_y_q;
    if (we_o) begin
      count_d = count_q + 1'b1;
      if (in_item_i.coord_x < min_x_q) min_x_d = in_item_i.coord_x;
      if (in_item_i.coord_x > max_x_q) max_x_d = in_item_i.coord_x;
      if (in_item_i.coord_y < min_y_q) min_y_d = in_item_i.coord_y;
      if (in_item_i.coord_y > max_y_q) max_y_d = in_item_i.coord_y;
    end else if (acc && in_item_i.command == CmdClear) begin
      count_d = '0;
      min_x_d = CoordMax;
      max_x_d = CoordMin;
      min_y_d = CoordMax;
      max_y_d = CoordMin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      min_x_q <= CoordMax;
      max_x_q <= CoordMin;
      min_y_q <= CoordMax;
      max_y_q <= CoordMin;
    end else begin
      count_q <= count_d;
      min_x_q <= min_x_d;
      max_x_q <= max_x_d;
      min_y_q <= min_y_d;
      max_y_q <= max_y_d;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(MaxPoints)) else $error("count overflow");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_i |-> !we_o && !job_valid_o) else $error("accept while busy");
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !we_o) else $error("write into full store");
endmodule

### rtl/whaq_back.sv
// ----------------------------------------------------------------------------
// whaq_back
// Scans the stored points for one query, sums the valid heights in the
// window and divides by the hit count one quotient bit per cycle.
// ----------------------------------------------------------------------------
module whaq_back import whaq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  job_t               job_i,
  output logic               busy_o,
  output logic [IdxBits-1:0] raddr_o,
  input  logic [PtBits-1:0]  rdata_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_item_o
);
  bk_state_e state_q, state_d;
  job_t job_q;
  logic job_pend_q;
  logic [CntBits-1:0] idx_q;
  logic signed [SumBits-1:0] sum_q;
  logic [CntBits-1:0] n_q;
  logic [SumBits-1:0] rem_q, quo_q;
  logic [$clog2(SumBits+1)-1:0] bit_q;
  logic neg_q;
  logic signed [CoordBits-1:0] px, py, pz;
  logic pok, hit;
  logic signed [CoordBits:0] dx, dy;
  logic [CoordBits:0] adx, ady;
  logic [SumBits:0] trial;
  logic signed [CoordBits-1:0] res_h;
  logic ok;
  logic out_load;
  logic out_valid_q;
  out_item_t out_q;

  // short job queue: one entry holds a query until the back end takes it up
  assign busy_o = job_pend_q || state_q != BkIdle;
  assign raddr_o = idx_q[IdxBits-1:0];
  assign {px, py, pz, pok} = rdata_i;

  assign dx  = (CoordBits+1)'(px) - (CoordBits+1)'(job_q.qx);
  assign dy  = (CoordBits+1)'(py) - (CoordBits+1)'(job_q.qy);
  assign adx = dx[CoordBits] ? (CoordBits+1)'(-dx) : (CoordBits+1)'(dx);
  assign ady = dy[CoordBits] ? (CoordBits+1)'(-dy) : (CoordBits+1)'(dy);
  assign hit = pok && adx <= (CoordBits+1)'(job_q.radius)
                   && ady <= (CoordBits+1)'(job_q.radius);

  assign trial = {rem_q, quo_q[SumBits-1]} - (SumBits+1)'(n_q);
  assign res_h = neg_q ? CoordBits'(-quo_q) : CoordBits'(quo_q);

  // output register takes the result once it is free
  assign out_load = state_q == BkOut && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle: if (job_pend_q) state_d = (job_q.in_bounds && job_q.count != '0) ? BkRead : BkOut;
      BkRead: state_d = BkScan;
      BkScan: if (idx_q == job_q.count) state_d = (n_q != '0 || hit) ? BkDiv : BkOut;
      BkDiv:  if (bit_q == '0) state_d = BkOut;
      BkOut:  if (out_load) state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      job_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (job_valid_i) job_pend_q <= 1'b1;
      else if (state_q == BkIdle) job_pend_q <= 1'b0;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i) job_q <= job_i;
    if (out_load) begin
      out_q.out_x     <= job_q.qx;
      out_q.out_y     <= job_q.qy;
      out_q.height    <= ok ? res_h : '0;
      out_q.height_ok <= ok;
    end
    unique case (state_q)
      BkIdle: begin
        idx_q <= '0;
        sum_q <= '0;
        n_q   <= '0;
      end
      BkRead: idx_q <= idx_q + 1'b1;
      BkScan: begin
        // data for entry idx_q-1 is at the RAM output
        if (hit) begin
          sum_q <= sum_q + SumBits'(pz);
          n_q   <= n_q + 1'b1;
        end
        if (idx_q != job_q.count) idx_q <= idx_q + 1'b1;
        neg_q <= sum_q[SumBits-1] ^ (hit & pz[CoordBits-1] & 1'b0);
        rem_q <= '0;
        bit_q <= ($clog2(SumBits+1))'(SumBits);
      end
      BkDiv: begin
        if (bit_q == ($clog2(SumBits+1))'(SumBits)) begin
          neg_q <= sum_q[SumBits-1];
          quo_q <= sum_q[SumBits-1] ? SumBits'(-sum_q) : SumBits'(sum_q);
          rem_q <= '0;
          bit_q <= bit_q - 1'b1;
        end else begin
          if (!trial[SumBits]) begin
            rem_q <= trial[SumBits-1:0];
            quo_q <= {quo_q[SumBits-2:0], 1'b1};
          end else begin
            rem_q <= {rem_q[SumBits-2:0], quo_q[SumBits-1]};
            quo_q <= {quo_q[SumBits-2:0], 1'b0};
          end
          bit_q <= bit_q - 1'b1;
        end
      end
      BkOut: ;
      default: ;
    endcase
  end

  // during the division bit_q counts SumBits down to 0
  assign ok = job_q.in_bounds && n_q != '0;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BkScan |-> idx_q <= job_q.count) else $error("scan index past count");
  a_hits_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BkScan |-> n_q < idx_q) else $error("hit count ahead of scan");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
endmodule

### rtl/window_height_average_query.sv
// ----------------------------------------------------------------------------
// window_height_average_query
// Point store with window height mean queries.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_valid_i/in_ready_o with an in_item_t payload.
// A load appends a point (dropped when the store is full) and a clear empties
// the store; neither gives a result. A query gives one
// out_item_t transaction on out_valid_o/out_ready_i.
// A query goes through the job register, a scan of the stored points (one
// stored point per cycle through the RAM read port), the bit-serial divide
// and the output register; a query outside the bounds or on an empty store
// skips the scan and the divide. One query is worked at a time; while it
// runs in_ready_o is low. A stalled receiver holds the result in the output
// register; loads and clears still go in, and a further query waits in the
// back end with in_ready_o low until the register frees up. Reset empties
// the store and resets the bounds at once; no clearing pass.
// ----------------------------------------------------------------------------
module window_height_average_query import whaq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);
  logic job_valid, busy, we;
  job_t job;
  logic [IdxBits-1:0] waddr, raddr;
  logic [PtBits-1:0] wdata, rdata;

  whaq_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .busy_i(busy), .job_valid_o(job_valid), .job_o(job),
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata)
  );

  whaq_ram #(.Width(PtBits), .Depth(MaxPoints)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  whaq_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_i(job), .busy_o(busy),
    .raddr_o(raddr), .rdata_i(rdata), .out_valid_o, .out_ready_i, .out_item_o
  );
endmodule

### bench/tb_window_height_average_query.sv
// ----------------------------------------------------------------------------
// tb_window_height_average_query
// Self-checking bench for the window height average query block: a queue-fed
// driver sends load, clear, query and no-op transactions, a behavioral point store
// predicts each query answer, and a monitor compares every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_window_height_average_query;
  import whaq_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  window_height_average_query uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic signed [CoordBits-1:0] pt_x [MaxPoints];
  logic signed [CoordBits-1:0] pt_y [MaxPoints];
  logic signed [CoordBits-1:0] pt_z [MaxPoints];
  logic                        pt_zok [MaxPoints];
  int unsigned                 pt_count;
  logic signed [CoordBits-1:0] min_x, max_x, min_y, max_y;

  in_item_t  pending_items[$];
  out_item_t expected_answers[$];
  int        errors = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        recv_hold = 1'b0;

  task automatic clear_store();
    pt_count = 0;
    min_x = CoordMax;
    max_x = CoordMin;
    min_y = CoordMax;
    max_y = CoordMin;
  endtask

  // apply one accepted transaction to the point store, or predict its answer for a query
  task automatic predict_window_mean(input in_item_t it);
    longint    sum, n, dx, dy, r;
    out_item_t res;
    case (cmd_e'(it.command))
      CmdLoad: begin
        if (pt_count < MaxPoints) begin
          pt_x[pt_count] = it.coord_x;
          pt_y[pt_count] = it.coord_y;
          pt_z[pt_count] = it.coord_z;
          pt_zok[pt_count] = it.z_present;
          pt_count++;
          if (it.coord_x < min_x) min_x = it.coord_x;
          if (it.coord_x > max_x) max_x = it.coord_x;
          if (it.coord_y < min_y) min_y = it.coord_y;
          if (it.coord_y > max_y) max_y = it.coord_y;
        end
      end
      CmdClear: clear_store();
      CmdQuery: begin
        sum = 0;
        n = 0;
        r = longint'(it.radius);
        res = '0;
        res.out_x = it.coord_x;
        res.out_y = it.coord_y;
        if (it.coord_x >= min_x && it.coord_x <= max_x &&
            it.coord_y >= min_y && it.coord_y <= max_y) begin
          for (int i = 0; i < pt_count; i++) begin
            dx = longint'(pt_x[i]) - longint'(it.coord_x);
            dy = longint'(pt_y[i]) - longint'(it.coord_y);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dx <= r && dy <= r && pt_zok[i]) begin
              sum += longint'(pt_z[i]);
              n++;
            end
          end
          if (n > 0) begin
            res.height = CoordBits'(sum / n);
            res.height_ok = 1'b1;
          end
        end
        expected_answers.push_back(res);
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      predict_window_mean(in_item_i);
      void'(pending_items.pop_front());
    end
    if (rst_ni && (!in_valid_i || in_ready_o)) begin
      // the front item is the one still on the bus until accepted
      if (pending_items.size() > (in_valid_i && in_ready_o ? 0 : 0) &&
          pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_item_i  <= pending_items[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk_i) begin
    out_ready_i <= rst_ni && !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor
  always @(posedge clk_i) begin
    out_item_t exp_res;
    if (out_valid_o && out_ready_i) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, out_item_o);
        errors++;
      end else begin
        exp_res = expected_answers.pop_front();
        if (out_item_o.out_x !== exp_res.out_x)
          $display("%0t: out_x mismatch, expected %0d actual %0d", $time,
                   exp_res.out_x, out_item_o.out_x);
        if (out_item_o.out_y !== exp_res.out_y)
          $display("%0t: out_y mismatch, expected %0d actual %0d", $time,
                   exp_res.out_y, out_item_o.out_y);
        if (out_item_o.height !== exp_res.height)
          $display("%0t: height mismatch, expected %0d actual %0d", $time,
                   exp_res.height, out_item_o.height);
        if (out_item_o.height_ok !== exp_res.height_ok)
          $display("%0t: height_ok mismatch, expected %0d actual %0d", $time,
                   exp_res.height_ok, out_item_o.height_ok);
        if (out_item_o !== exp_res) errors++;
      end
    end
  end

  function automatic in_item_t make_item(cmd_e c, int x, int y, int z, bit zp, int r);
    in_item_t it;
    it.command = c;
    it.coord_x = x[CoordBits-1:0];
    it.coord_y = y[CoordBits-1:0];
    it.coord_z = z[CoordBits-1:0];
    it.z_present = zp;
    it.radius = r[CoordBits-2:0];
    return it;
  endfunction

  function automatic int rand_coord();
    return int'($signed($urandom_range(32'hFFFFFF, 0) << 8)) >>> 8;
  endfunction

  // one cluster: maybe a clear, loads near a center, queries mostly around it, no-ops
  task automatic queue_cluster(input int n_loads, input int n_queries);
    int cx, cy, spread;
    cx = $urandom_range(1) ? rand_coord() : $signed($urandom_range(400)) - 200;
    cy = $urandom_range(1) ? rand_coord() : $signed($urandom_range(400)) - 200;
    spread = $urandom_range(1) ? 50 : 100000;
    if ($urandom_range(3) != 0) pending_items.push_back(make_item(CmdClear,
        rand_coord(), rand_coord(), rand_coord(), $urandom_range(1), $urandom()));
    for (int i = 0; i < n_loads; i++) begin
      pending_items.push_back(make_item(CmdLoad,
        cx + $signed($urandom_range(2 * spread)) - spread,
        cy + $signed($urandom_range(2 * spread)) - spread,
        rand_coord(), $urandom_range(3) != 0, $urandom()));
    end
    for (int i = 0; i < n_queries; i++) begin
      case ($urandom_range(5))
        0: pending_items.push_back(make_item(CmdQuery, rand_coord(), rand_coord(),
             0, 0, $urandom()));
        1: pending_items.push_back(make_item(CmdNone, rand_coord(), rand_coord(),
             rand_coord(), 1, $urandom()));
        default: pending_items.push_back(make_item(CmdQuery,
             cx + $signed($urandom_range(2 * spread)) - spread,
             cy + $signed($urandom_range(2 * spread)) - spread,
             rand_coord(), $urandom_range(1),
             $urandom_range(1) ? $urandom_range(2 * spread) : $urandom()));
      endcase
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_answers.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    clear_store();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty store, extremes, invalid heights, dropped command
    pending_items.push_back(make_item(CmdQuery, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(CmdLoad, -8388608, -8388608, -8388608, 1, 0));
    pending_items.push_back(make_item(CmdLoad, 8388607, 8388607, 8388607, 1, 0));
    pending_items.push_back(make_item(CmdLoad, 0, 0, 1234, 0, 0));
    pending_items.push_back(make_item(CmdLoad, 1, -1, -7, 1, 0));
    pending_items.push_back(make_item(CmdLoad, 1, 0, -2, 1, 0));
    pending_items.push_back(make_item(CmdQuery, -8388608, -8388608, 0, 0, 8388607));
    pending_items.push_back(make_item(CmdQuery, 8388607, 8388607, -1, 1, 0));
    pending_items.push_back(make_item(CmdQuery, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(CmdQuery, 0, 0, 0, 0, 1));
    pending_items.push_back(make_item(CmdQuery, 5, 5, 0, 0, 1));
    pending_items.push_back(make_item(CmdQuery, 0, 0, 0, 0, 8388607));
    pending_items.push_back(make_item(CmdNone, 3, 3, 3, 1, 3));
    pending_items.push_back(make_item(CmdClear, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(CmdQuery, 0, 0, 0, 0, 8388607));
    pending_items.push_back(make_item(CmdLoad, 10, 10, -5, 1, 0));
    pending_items.push_back(make_item(CmdQuery, 10, 10, 0, 0, 0));
    pending_items.push_back(make_item(CmdQuery, 11, 10, 0, 0, 0));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 84 : 33) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 84 : 33) : 0;
      for (int k = 0; k < 3; k++)
        queue_cluster($urandom_range(8, 3), $urandom_range(5, 2));
      if (ph == 0) begin
        // long receiver hold while the sender keeps offering queries
        recv_hold = 1'b1;
        repeat (300) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("window_height_average_query test passed");
    end else begin
      $display("window_height_average_query test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("window_height_average_query test failed");
    $finish;
  end

endmodule
